>>> rtl/rls_pkg.sv
// shared types and constants for the richardson linear solver
// no dependencies

package rls_pkg;

	localparam int MAX_SIZE = 64;
	localparam int IDX_W    = $clog2(MAX_SIZE);
	localparam int DIM_W    = IDX_W + 1;
	localparam int ADDR_A_W = 2 * IDX_W;

	// input item commands
	localparam logic [1:0] CMD_MATRIX = 2'd0;
	localparam logic [1:0] CMD_RHS    = 2'd1;
	localparam logic [1:0] CMD_GUESS  = 2'd2;
	localparam logic [1:0] CMD_START  = 2'd3;

	// configuration register indexes
	localparam logic [1:0] REG_ACTIVE_SIZE = 2'd0;
	localparam logic [1:0] REG_STEP_SIZE   = 2'd1;
	localparam logic [1:0] REG_TOLERANCE   = 2'd2;
	localparam logic [1:0] REG_ITER_LIMIT  = 2'd3;

	// datapath operations
	localparam logic [3:0] OP_NONE     = 4'd0;
	localparam logic [3:0] OP_LOAD     = 4'd1;
	localparam logic [3:0] OP_CLEAR    = 4'd2;
	localparam logic [3:0] OP_READ     = 4'd3;
	localparam logic [3:0] OP_READ_AX  = 4'd4;
	localparam logic [3:0] OP_SQ_B     = 4'd5;
	localparam logic [3:0] OP_ADD_BN   = 4'd6;
	localparam logic [3:0] OP_TOL_MUL  = 4'd7;
	localparam logic [3:0] OP_TOL_ADD  = 4'd8;
	localparam logic [3:0] OP_INIT_RN  = 4'd9;
	localparam logic [3:0] OP_TAU_MUL  = 4'd10;
	localparam logic [3:0] OP_X_UPD    = 4'd11;
	localparam logic [3:0] OP_ACC_CLR  = 4'd12;
	localparam logic [3:0] OP_AX_MUL   = 4'd13;
	localparam logic [3:0] OP_AX_ACC   = 4'd14;
	localparam logic [3:0] OP_RES_DIFF = 4'd15;

	// second group shares codes via a separate field to keep op narrow
	typedef struct packed {
		logic [3:0]       op;
		logic             sq_r;      // square new residual
		logic             add_rn;    // accumulate residual norm
		logic             pass_clr;  // clear residual norm at pass start
		logic             emit;      // present one result
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic             last;
		logic             conv;
		logic [31:0]      passes;
	} ctl_t;

	typedef struct packed {
		logic conv;
	} sts_t;

endpackage

>>> rtl/rls_ctrl.sv
// sequencer for the richardson linear solver
// depends on rls_pkg

module rls_ctrl import rls_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [1:0]       command,
	input  logic [DIM_W-1:0] active_size,
	input  logic [31:0]      iteration_limit,
	input  sts_t             sts,
	output logic             busy,
	output ctl_t             ctl
);

	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_B_RD  = 5'd1;
	localparam logic [4:0] S_B_SQ  = 5'd2;
	localparam logic [4:0] S_B_ADD = 5'd3;
	localparam logic [4:0] S_T_MUL = 5'd4;
	localparam logic [4:0] S_T_ADD = 5'd5;
	localparam logic [4:0] S_INIT  = 5'd6;
	localparam logic [4:0] S_TEST  = 5'd7;
	localparam logic [4:0] S_P_CLR = 5'd8;
	localparam logic [4:0] S_U_RD  = 5'd9;
	localparam logic [4:0] S_U_MUL = 5'd10;
	localparam logic [4:0] S_U_WR  = 5'd11;
	localparam logic [4:0] S_M_CLR = 5'd12;
	localparam logic [4:0] S_M_RD  = 5'd13;
	localparam logic [4:0] S_M_MUL = 5'd14;
	localparam logic [4:0] S_M_ACC = 5'd15;
	localparam logic [4:0] S_R_DIF = 5'd16;
	localparam logic [4:0] S_R_SQ  = 5'd17;
	localparam logic [4:0] S_R_ADD = 5'd18;
	localparam logic [4:0] S_E_RD  = 5'd19;
	localparam logic [4:0] S_E_OUT = 5'd20;

	logic [4:0]       state_q;
	logic [IDX_W-1:0] row_q, col_q;
	logic [31:0]      passes_q;
	logic             conv_q;
	logic [IDX_W-1:0] dim_last;
	logic             row_end, col_end;

	always_comb begin
		if (active_size == '0)
			dim_last = '0;
		else if (active_size > DIM_W'(MAX_SIZE))
			dim_last = IDX_W'(MAX_SIZE - 1);
		else
			dim_last = IDX_W'(active_size - DIM_W'(1));
	end

	assign row_end = (row_q == dim_last);
	assign col_end = (col_q == dim_last);
	assign busy    = (state_q != S_IDLE);

	always_comb begin
		ctl          = '0;
		ctl.row      = row_q;
		ctl.col      = col_q;
		ctl.last     = row_end;
		ctl.conv     = conv_q;
		ctl.passes   = passes_q;
		unique case (state_q)
			S_IDLE: begin
				if (start)
					ctl.op = (command == CMD_START) ? OP_CLEAR : OP_LOAD;
			end
			S_B_RD:  ctl.op = OP_READ;
			S_B_SQ:  ctl.op = OP_SQ_B;
			S_B_ADD: ctl.op = OP_ADD_BN;
			S_T_MUL: ctl.op = OP_TOL_MUL;
			S_T_ADD: ctl.op = OP_TOL_ADD;
			S_INIT:  ctl.op = OP_INIT_RN;
			S_TEST:  ctl.op = OP_NONE;
			S_P_CLR: ctl.pass_clr = 1'b1;
			S_U_RD:  ctl.op = OP_READ;
			S_U_MUL: ctl.op = OP_TAU_MUL;
			S_U_WR:  ctl.op = OP_X_UPD;
			S_M_CLR: ctl.op = OP_ACC_CLR;
			S_M_RD:  ctl.op = OP_READ_AX;
			S_M_MUL: ctl.op = OP_AX_MUL;
			S_M_ACC: ctl.op = OP_AX_ACC;
			S_R_DIF: ctl.op = OP_RES_DIFF;
			S_R_SQ:  ctl.sq_r = 1'b1;
			S_R_ADD: ctl.add_rn = 1'b1;
			S_E_RD:  ctl.op = OP_READ;
			S_E_OUT: ctl.emit = 1'b1;
			default: ctl.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			row_q    <= '0;
			col_q    <= '0;
			passes_q <= '0;
			conv_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start && command == CMD_START) begin
						row_q    <= '0;
						passes_q <= '0;
						state_q  <= S_B_RD;
					end
				end
				S_B_RD:  state_q <= S_B_SQ;
				S_B_SQ:  state_q <= S_B_ADD;
				S_B_ADD: begin
					col_q <= '0;
					if (row_end) begin
						state_q <= S_T_MUL;
					end else begin
						row_q   <= row_q + 1'b1;
						state_q <= S_B_RD;
					end
				end
				S_T_MUL: state_q <= S_T_ADD;
				S_T_ADD: begin
					if (col_q[1:0] == 2'd3) begin
						state_q <= S_INIT;
					end else begin
						col_q   <= col_q + 1'b1;
						state_q <= S_T_MUL;
					end
				end
				S_INIT:  state_q <= S_TEST;
				S_TEST: begin
					conv_q <= sts.conv;
					row_q  <= '0;
					col_q  <= '0;
					if (sts.conv || passes_q == iteration_limit) begin
						state_q <= S_E_RD;
					end else begin
						passes_q <= passes_q + 1'b1;
						state_q  <= S_P_CLR;
					end
				end
				S_P_CLR: state_q <= S_U_RD;
				S_U_RD:  state_q <= S_U_MUL;
				S_U_MUL: state_q <= S_U_WR;
				S_U_WR: begin
					if (row_end) begin
						row_q   <= '0;
						state_q <= S_M_CLR;
					end else begin
						row_q   <= row_q + 1'b1;
						state_q <= S_U_RD;
					end
				end
				S_M_CLR: begin
					col_q   <= '0;
					state_q <= S_M_RD;
				end
				S_M_RD:  state_q <= S_M_MUL;
				S_M_MUL: state_q <= S_M_ACC;
				S_M_ACC: begin
					if (col_end) begin
						state_q <= S_R_DIF;
					end else begin
						col_q   <= col_q + 1'b1;
						state_q <= S_M_RD;
					end
				end
				S_R_DIF: state_q <= S_R_SQ;
				S_R_SQ:  state_q <= S_R_ADD;
				S_R_ADD: begin
					if (row_end) begin
						state_q <= S_TEST;
					end else begin
						row_q   <= row_q + 1'b1;
						state_q <= S_M_CLR;
					end
				end
				S_E_RD:  state_q <= S_E_OUT;
				S_E_OUT: begin
					if (row_end) begin
						state_q <= S_IDLE;
					end else begin
						row_q   <= row_q + 1'b1;
						state_q <= S_E_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> rtl/rls_datapath.sv
// stores, shared multiplier, saturating accumulators and result register
// depends on rls_pkg

module rls_datapath import rls_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  ctl_t               ctl,
	input  logic [1:0]         ld_command,
	input  logic [IDX_W-1:0]   ld_row,
	input  logic [IDX_W-1:0]   ld_col,
	input  logic signed [31:0] ld_value,
	input  logic signed [31:0] step_size,
	input  logic [47:0]        tolerance_sq,
	output sts_t               sts,
	output logic               res_valid,
	output logic [IDX_W-1:0]   res_index,
	output logic signed [31:0] res_solution,
	output logic               res_last,
	output logic               res_converged,
	output logic [31:0]        res_passes
);

	// q16.48 to q17.24, round half up
	function automatic logic signed [40:0] round_q24(input logic signed [63:0] v);
		round_q24 = {v[63], v[63:24]} + {40'd0, v[23]};
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
		if (v > 42'sh0007FFFFFFF)
			sat32 = 32'sh7FFFFFFF;
		else if (v < -42'sh00080000000)
			sat32 = 32'sh80000000;
		else
			sat32 = v[31:0];
	endfunction

	function automatic logic [63:0] sat_fix64(input logic [64:0] s);
		if (s[64] != s[63])
			sat_fix64 = s[64] ? 64'h8000000000000000 : 64'h7FFFFFFFFFFFFFFF;
		else
			sat_fix64 = s[63:0];
	endfunction

	function automatic logic [63:0] usat_add64(input logic [63:0] p, input logic [63:0] q);
		logic [64:0] s;
		s = {1'b0, p} + {1'b0, q};
		usat_add64 = s[64] ? '1 : s[63:0];
	endfunction

	logic signed [31:0] a_mem [MAX_SIZE*MAX_SIZE];
	logic signed [31:0] b_mem [MAX_SIZE];
	logic signed [31:0] x_mem [MAX_SIZE];
	logic signed [31:0] r_mem [MAX_SIZE];
	logic [MAX_SIZE-1:0] x_vld_q, r_vld_q;

	logic signed [31:0] a_q, b_q, x_raw_q, r_raw_q, rnew_q;
	logic               xv_q, rv_q;
	logic signed [31:0] x_rd, r_rd;
	logic signed [63:0] prod_q, acc_q;
	logic [63:0]        rhs_norm_q, res_norm_q;
	logic [111:0]       tolp_q;

	logic               rd_en;
	logic [IDX_W-1:0]   x_raddr, x_waddr;
	logic               x_we;
	logic signed [31:0] x_wdata, x_new, r_new;
	logic signed [32:0] m_a, m_b;
	logic signed [65:0] m_full;
	logic signed [63:0] b_wide, diff;
	logic [111:0]       tol_term;

	assign rd_en   = (ctl.op == OP_READ) || (ctl.op == OP_READ_AX);
	assign x_raddr = (ctl.op == OP_READ_AX) ? ctl.col : ctl.row;
	assign x_rd    = xv_q ? x_raw_q : 32'sd0;
	assign r_rd    = rv_q ? r_raw_q : 32'sd0;

	assign x_new  = sat32(42'(x_rd) - 42'(round_q24(prod_q)));
	assign b_wide = {{8{b_q[31]}}, b_q, 24'd0};
	assign diff   = $signed(sat_fix64({b_wide[63], b_wide} - {acc_q[63], acc_q}));
	assign r_new  = sat32(42'(round_q24(diff)));

	assign x_we    = (ctl.op == OP_LOAD && ld_command == CMD_GUESS) || ctl.op == OP_X_UPD;
	assign x_waddr = (ctl.op == OP_LOAD) ? ld_row : ctl.row;
	assign x_wdata = (ctl.op == OP_LOAD) ? ld_value : x_new;

	// shared multiplier operand select
	always_comb begin
		m_a = '0;
		m_b = '0;
		if (ctl.sq_r) begin
			m_a = 33'(rnew_q);
			m_b = 33'(rnew_q);
		end else begin
			case (ctl.op)
				OP_SQ_B: begin
					m_a = 33'(b_q);
					m_b = 33'(b_q);
				end
				OP_TOL_MUL: begin
					m_a = ctl.col[1] ? {9'd0, tolerance_sq[47:24]} : {9'd0, tolerance_sq[23:0]};
					m_b = (ctl.col[1:0] == 2'd1 || ctl.col[1:0] == 2'd3)
						? {1'b0, rhs_norm_q[63:32]} : {1'b0, rhs_norm_q[31:0]};
				end
				OP_TAU_MUL: begin
					m_a = 33'(step_size);
					m_b = 33'(r_rd);
				end
				OP_AX_MUL: begin
					m_a = 33'(a_q);
					m_b = 33'(x_rd);
				end
				default: begin
					m_a = '0;
					m_b = '0;
				end
			endcase
		end
	end

	assign m_full = m_a * m_b;

	// partial product placement for tolerance times rhs norm
	always_comb begin
		case (ctl.col[1:0])
			2'd0:    tol_term = {48'd0, prod_q};
			2'd1:    tol_term = {16'd0, prod_q, 32'd0};
			2'd2:    tol_term = {24'd0, prod_q, 24'd0};
			default: tol_term = {prod_q[55:0], 56'd0};
		endcase
	end

	assign sts.conv = (rhs_norm_q == '0) || ({res_norm_q, 48'd0} < tolp_q);

	// stores
	always_ff @(posedge clk) begin
		if (ctl.op == OP_LOAD && ld_command == CMD_MATRIX)
			a_mem[{ld_row, ld_col}] <= ld_value;
		if (ctl.op == OP_LOAD && ld_command == CMD_RHS)
			b_mem[ld_row] <= ld_value;
		if (x_we)
			x_mem[x_waddr] <= x_wdata;
		if (ctl.op == OP_RES_DIFF)
			r_mem[ctl.row] <= r_new;
		if (rd_en) begin
			a_q     <= a_mem[{ctl.row, ctl.col}];
			b_q     <= b_mem[ctl.row];
			x_raw_q <= x_mem[x_raddr];
			r_raw_q <= r_mem[ctl.row];
			xv_q    <= x_vld_q[x_raddr];
			rv_q    <= r_vld_q[ctl.row];
		end
		prod_q <= m_full[63:0];
		if (ctl.op == OP_RES_DIFF)
			rnew_q <= r_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_vld_q    <= '0;
			r_vld_q    <= '0;
			acc_q      <= '0;
			rhs_norm_q <= '0;
			res_norm_q <= '0;
			tolp_q     <= '0;
		end else begin
			if (x_we)
				x_vld_q[x_waddr] <= 1'b1;
			if (ctl.pass_clr)
				res_norm_q <= '0;
			if (ctl.add_rn)
				res_norm_q <= usat_add64(res_norm_q, prod_q);
			case (ctl.op)
				OP_CLEAR: begin
					r_vld_q    <= '0;
					rhs_norm_q <= '0;
					tolp_q     <= '0;
				end
				OP_ADD_BN:   rhs_norm_q <= usat_add64(rhs_norm_q, prod_q);
				OP_TOL_ADD:  tolp_q <= tolp_q + tol_term;
				OP_INIT_RN:  res_norm_q <= rhs_norm_q;
				OP_ACC_CLR:  acc_q <= '0;
				OP_AX_ACC:   acc_q <= $signed(sat_fix64({acc_q[63], acc_q} + {prod_q[63], prod_q}));
				OP_RES_DIFF: r_vld_q[ctl.row] <= 1'b1;
				default: ;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid <= 1'b0;
		else
			res_valid <= ctl.emit;
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			res_index     <= ctl.row;
			res_solution  <= x_rd;
			res_last      <= ctl.last;
			res_converged <= ctl.conv;
			res_passes    <= ctl.passes;
		end
	end

endmodule

>>> rtl/richardson_linear_solver.sv
// top level of the richardson linear solver: configuration registers,
// sequencer and datapath; depends on rls_pkg, rls_ctrl, rls_datapath
//
// usage:
//  - input items enter on start/command/row/column/value when start is high
//    and busy is low. matrix, rhs and guess loads give no result; busy
//    stays low, so loads stream one per cycle
//  - a start item (command 3) runs the solve; busy stays high until the last
//    solution item is on the result ports
//  - a solve runs in phases: setup (rhs norm, the four partial products of
//    tolerance times rhs norm and the first test), then the passes, then the
//    output of the solution items. in the row sums the shared multiplier
//    serves one matrix entry at a time, in read, multiply and accumulate
//    steps
//  - results: valid is high for one cycle per item with index, solution,
//    last, converged and passes. the receiver cannot stall the block; every
//    item must be taken in its cycle
//  - configuration: cfg_we, cfg_index, cfg_data write a register; write
//    only while busy is low, the block itself does not enforce this
//  - reset: registers take their reset values, guess and residual stores
//    read as zero, matrix and rhs stores hold nothing defined

module richardson_linear_solver import rls_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         command,
	input  logic [5:0]         row,
	input  logic [5:0]         column,
	input  logic signed [31:0] value,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [47:0]        cfg_data,
	output logic               valid,
	output logic [5:0]         index,
	output logic signed [31:0] solution,
	output logic               last,
	output logic               converged,
	output logic [31:0]        passes
);

	logic [DIM_W-1:0]   active_size_q;
	logic signed [31:0] step_size_q;
	logic [47:0]        tolerance_sq_q;
	logic [31:0]        iteration_limit_q;

	ctl_t ctl;
	sts_t sts;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_size_q     <= DIM_W'(MAX_SIZE);
			step_size_q       <= -32'sd168;
			tolerance_sq_q    <= 48'd1;
			iteration_limit_q <= 32'd1048576;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ACTIVE_SIZE: active_size_q     <= cfg_data[DIM_W-1:0];
				REG_STEP_SIZE:   step_size_q       <= cfg_data[31:0];
				REG_TOLERANCE:   tolerance_sq_q    <= cfg_data;
				REG_ITER_LIMIT:  iteration_limit_q <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	rls_ctrl u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.command         (command),
		.active_size     (active_size_q),
		.iteration_limit (iteration_limit_q),
		.sts             (sts),
		.busy            (busy),
		.ctl             (ctl)
	);

	rls_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.ld_command    (command),
		.ld_row        (row),
		.ld_col        (column),
		.ld_value      (value),
		.step_size     (step_size_q),
		.tolerance_sq  (tolerance_sq_q),
		.sts           (sts),
		.res_valid     (valid),
		.res_index     (index),
		.res_solution  (solution),
		.res_last      (last),
		.res_converged (converged),
		.res_passes    (passes)
	);

endmodule

>>> test/tb.sv
// self-checking testbench for richardson_linear_solver: loads, solves and
// checks every solution item against an in-bench fixed-point predictor
// depends on rls_pkg and the richardson_linear_solver rtl

module tb;
	import rls_pkg::*;

	typedef struct {
		logic [1:0]  cmd;
		logic [5:0]  r;
		logic [5:0]  c;
		logic [31:0] v;
	} load_item_t;

	typedef struct {
		logic [5:0]  idx;
		logic [31:0] sol;
		logic        lst;
		logic        conv;
		logic [31:0] npass;
	} sol_item_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [1:0]         command;
	logic [5:0]         row;
	logic [5:0]         column;
	logic signed [31:0] value;
	logic               cfg_we;
	logic [1:0]         cfg_index;
	logic [47:0]        cfg_data;
	logic               valid;
	logic [5:0]         index;
	logic signed [31:0] solution;
	logic               last;
	logic               converged;
	logic [31:0]        passes;

	richardson_linear_solver dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.command(command), .row(row), .column(column), .value(value),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.valid(valid), .index(index), .solution(solution), .last(last),
		.converged(converged), .passes(passes)
	);

	// items waiting for the driver, solution items waiting for the block
	load_item_t pending_items[$];
	sol_item_t  expected_solutions[$];

	// predictor copy of stores and registers
	logic [31:0]  m_matrix [0:4095];
	logic [31:0]  m_rhs    [0:63];
	logic [31:0]  m_x      [0:63];
	logic [31:0]  m_res    [0:63];
	logic [63:0]  m_res_norm;
	logic [63:0]  m_rhs_norm;
	logic [6:0]   m_size;
	logic [31:0]  m_tau;
	logic [47:0]  m_tol;
	logic [31:0]  m_limit;

	// generator bookkeeping: which matrix and rhs entries were ever loaded
	bit           seen_a [0:4095];
	bit           seen_b [0:63];

	int  idle_mode;
	int  errors;
	int  items_queued;
	int  solves_done;
	int  results_checked;

	// ---------------- fixed-point helpers ----------------

	function automatic longint round_q24(longint v);
		return (v >>> 24) + longint'(v[23]);
	endfunction

	function automatic logic [31:0] clip32(longint v);
		if (v > 64'sd2147483647)
			return 32'h7FFF_FFFF;
		if (v < -64'sd2147483648)
			return 32'h8000_0000;
		return v[31:0];
	endfunction

	function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
		logic [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63])
			return s[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
		return s[63:0];
	endfunction

	function automatic logic [63:0] sub_sat(logic [63:0] a, logic [63:0] b);
		logic [64:0] s;
		s = {a[63], a} - {b[63], b};
		if (s[64] != s[63])
			return s[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
		return s[63:0];
	endfunction

	function automatic logic [63:0] uadd_sat(logic [63:0] a, logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
	endfunction

	function automatic logic [63:0] square_q(logic [31:0] v);
		longint w;
		w = longint'(signed'(v));
		return w * w;
	endfunction

	// |res|^2 * 2^48 < tol * |b|^2, exact
	function automatic bit tolerance_reached();
		logic [127:0] lhs, rhs;
		if (m_rhs_norm == 0)
			return 1;
		lhs = {16'b0, m_res_norm, 48'b0};
		rhs = 128'(m_tol) * 128'(m_rhs_norm);
		return lhs < rhs;
	endfunction

	// run one solve on the predictor and queue its solution items
	task automatic predict_solve();
		int     dim;
		longint done;
		bit     conv;
		longint corr;
		logic [63:0] acc;
		sol_item_t s;
		dim = m_size;
		if (dim < 1)
			dim = 1;
		if (dim > 64)
			dim = 64;
		for (int r = 0; r < 64; r++)
			m_res[r] = 0;
		m_rhs_norm = 0;
		for (int r = 0; r < dim; r++)
			m_rhs_norm = uadd_sat(m_rhs_norm, square_q(m_rhs[r]));
		m_res_norm = m_rhs_norm;
		done = 0;
		conv = tolerance_reached();
		while (!conv && done < longint'(m_limit)) begin
			for (int r = 0; r < dim; r++) begin
				corr = round_q24(longint'(signed'(m_tau)) * longint'(signed'(m_res[r])));
				m_x[r] = clip32(longint'(signed'(m_x[r])) - corr);
			end
			m_res_norm = 0;
			for (int r = 0; r < dim; r++) begin
				acc = 0;
				for (int c = 0; c < dim; c++)
					acc = add_sat(acc, longint'(signed'(m_matrix[r * 64 + c])) *
						longint'(signed'(m_x[c])));
				acc = sub_sat(longint'(signed'(m_rhs[r])) * 64'sd16777216, acc);
				m_res[r] = clip32(round_q24(acc));
				m_res_norm = uadd_sat(m_res_norm, square_q(m_res[r]));
			end
			done++;
			conv = tolerance_reached();
		end
		for (int r = 0; r < dim; r++) begin
			s.idx   = r[5:0];
			s.sol   = m_x[r];
			s.lst   = (r + 1 == dim);
			s.conv  = conv;
			s.npass = done[31:0];
			expected_solutions.insert(expected_solutions.size(), s);
		end
		solves_done++;
	endtask

	// ---------------- clock, reset, watchdog ----------------

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("timeout at %0t", $time);
		$display("TEST FAILED");
		$finish;
	end

	// ---------------- driver ----------------

	// presents the front item at the falling edge; sender gaps per idle_mode
	always @(negedge clk) begin
		bit gap;
		case (idle_mode)
			1:       gap = ($urandom_range(0, 99) < 87);
			2:       gap = ($urandom_range(0, 99) < 6);
			default: gap = 0;
		endcase
		if (arst_n && pending_items.size() > 0 && !gap) begin
			start   <= 1'b1;
			command <= pending_items[0].cmd;
			row     <= pending_items[0].r;
			column  <= pending_items[0].c;
			value   <= pending_items[0].v;
		end else begin
			start <= 1'b0;
		end
	end

	// ---------------- monitor: acceptance and result check ----------------

	always @(posedge clk) begin
		sol_item_t e;
		if (arst_n && start && !busy) begin
			void'(pending_items.pop_front());
			case (command)
				CMD_MATRIX: m_matrix[{row, column}] = value;
				CMD_RHS:    m_rhs[row] = value;
				CMD_GUESS:  m_x[row] = value;
				CMD_START:  predict_solve();
			endcase
		end
		if (arst_n && valid) begin
			if (expected_solutions.size() == 0) begin
				$display("%0t: unexpected result index %0d solution %h", $time, index,
					solution);
				errors++;
			end else begin
				e = expected_solutions.pop_front();
				results_checked++;
				if (index !== e.idx || solution !== e.sol || last !== e.lst ||
					converged !== e.conv || passes !== e.npass) begin
					$display("%0t: mismatch exp idx %0d x %h last %b conv %b passes %0d",
						$time, e.idx, e.sol, e.lst, e.conv, e.npass);
					$display("%0t:          got idx %0d x %h last %b conv %b passes %0d",
						$time, index, solution, last, converged, passes);
					errors++;
				end
			end
		end
	end

	// ---------------- stimulus helpers ----------------

	task automatic queue_item(logic [1:0] cmd, int r, int c, logic [31:0] v);
		load_item_t it;
		it.cmd = cmd;
		it.r   = r[5:0];
		it.c   = c[5:0];
		it.v   = v;
		pending_items.insert(pending_items.size(), it);
		items_queued++;
		if (cmd == CMD_MATRIX)
			seen_a[r * 64 + c] = 1;
		if (cmd == CMD_RHS)
			seen_b[r] = 1;
	endtask

	// waits until the block has drained, loads included
	task automatic wait_drained();
		wait (pending_items.size() == 0);
		do begin
			@(negedge clk);
			wait (expected_solutions.size() == 0);
			repeat (8) @(negedge clk);
		end while (busy || expected_solutions.size() != 0);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [47:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			REG_ACTIVE_SIZE: m_size  = data[6:0];
			REG_STEP_SIZE:   m_tau   = data[31:0];
			REG_TOLERANCE:   m_tol   = data;
			REG_ITER_LIMIT:  m_limit = data[31:0];
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_config(logic [6:0] sz, logic [31:0] tau, logic [47:0] tol,
		logic [31:0] lim);
		logic [47:0] junk;
		wait_drained();
		// upper bits beyond each register's width are don't-care, so randomize them
		junk = {$urandom, $urandom};
		write_reg(REG_ACTIVE_SIZE, {junk[47:7], sz});
		write_reg(REG_STEP_SIZE, {junk[47:32], tau});
		write_reg(REG_TOLERANCE, tol);
		write_reg(REG_ITER_LIMIT, {~junk[47:32], lim});
	endtask

	function automatic logic [31:0] any_value();
		case ($urandom_range(0, 5))
			0:       return 32'h7FFF_FFFF;
			1:       return 32'h8000_0000;
			2:       return 0;
			default: return $urandom;
		endcase
	endfunction

	// near-identity system, for which tau = -0.5 converges, with occasional arbitrary entries and noisy stray loads
	task automatic load_system(int n, bit noisy);
		for (int r = 0; r < n; r++) begin
			for (int c = 0; c < n; c++) begin
				if (noisy && $urandom_range(0, 9) == 0)
					queue_item(CMD_MATRIX, $urandom_range(0, 63), $urandom_range(0, 63),
						any_value());
				if ($urandom_range(0, 19) == 0)
					queue_item(CMD_MATRIX, r, c, any_value());
				else if (r == c)
					queue_item(CMD_MATRIX, r, c, 32'h0100_0000 + $urandom_range(0, 1 << 22));
				else
					queue_item(CMD_MATRIX, r, c, $urandom_range(0, 1 << 20) - (1 << 19));
			end
			queue_item(CMD_RHS, r, 0, ($urandom_range(0, 1) ? any_value() :
				$urandom_range(0, 1 << 26) - (1 << 25)));
			queue_item(CMD_GUESS, r, $urandom_range(0, 63), $urandom_range(0, 1) ?
				any_value() : 32'h0);
		end
	endtask

	function automatic bit system_loaded(int n);
		for (int r = 0; r < n; r++) begin
			if (!seen_b[r])
				return 0;
			for (int c = 0; c < n; c++)
				if (!seen_a[r * 64 + c])
					return 0;
		end
		return 1;
	endfunction

	// ---------------- main sequence ----------------

	initial begin
		logic [31:0] tau_pick;
		logic [47:0] tol_pick;
		int          n;
		arst_n    = 0;
		start     = 0;
		command   = CMD_MATRIX;
		row       = 0;
		column    = 0;
		value     = 0;
		cfg_we    = 0;
		cfg_index = REG_ACTIVE_SIZE;
		cfg_data  = 0;
		idle_mode = 0;
		errors = 0;
		items_queued = 0;
		solves_done = 0;
		results_checked = 0;
		m_size = 64;
		m_tau = -32'sd168;
		m_tol = 1;
		m_limit = 1048576;
		m_res_norm = 0;
		m_rhs_norm = 0;
		for (int i = 0; i < 64; i++) begin
			m_rhs[i] = 0;
			m_x[i] = 0;
			m_res[i] = 0;
			seen_b[i] = 0;
		end
		for (int i = 0; i < 4096; i++) begin
			m_matrix[i] = 0;
			seen_a[i] = 0;
		end
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: 2x2 with extreme entries
		set_config(2, 32'hFF80_0000, 48'h0100_0000_0000, 30);
		queue_item(CMD_MATRIX, 0, 0, 32'h7FFF_FFFF);
		queue_item(CMD_MATRIX, 0, 1, 32'h8000_0000);
		queue_item(CMD_MATRIX, 1, 0, 32'h0);
		queue_item(CMD_MATRIX, 1, 1, 32'h0100_0000);
		queue_item(CMD_RHS, 0, 0, 32'h8000_0000);
		queue_item(CMD_RHS, 1, 0, 32'h7FFF_FFFF);
		queue_item(CMD_GUESS, 0, 0, 32'h7FFF_FFFF);
		queue_item(CMD_GUESS, 1, 0, 32'h8000_0000);
		queue_item(CMD_START, 0, 0, 0);
		// well-behaved identity system
		queue_item(CMD_MATRIX, 0, 0, 32'h0100_0000);
		queue_item(CMD_MATRIX, 0, 1, 32'h0);
		queue_item(CMD_MATRIX, 1, 0, 32'h0);
		queue_item(CMD_RHS, 0, 0, 32'h0300_0000);
		queue_item(CMD_RHS, 1, 0, 32'hFE00_0000);
		queue_item(CMD_START, 0, 0, 0);
		// zero right-hand side: converged at once with zero passes
		queue_item(CMD_RHS, 0, 0, 0);
		queue_item(CMD_RHS, 1, 0, 0);
		queue_item(CMD_START, 0, 0, 0);
		// zero iteration limit, extreme step sizes, zero and full tolerance
		queue_item(CMD_RHS, 0, 0, 32'h0100_0000);
		set_config(2, 32'h7FFF_FFFF, 48'hFFFF_FFFF_FFFF, 0);
		queue_item(CMD_START, 0, 0, 0);
		set_config(2, 32'h8000_0000, 48'h0, 3);
		queue_item(CMD_START, 0, 0, 0);
		// size zero acts as one
		set_config(0, 32'hFF80_0000, 48'h0000_0100_0000, 5);
		queue_item(CMD_START, 0, 0, 0);

		// random phases, small systems, idling mode rotates
		for (int ph = 0; items_queued < 375; ph++) begin
			n = $urandom_range(1, 8);
			case ($urandom_range(0, 4))
				0:       tau_pick = 32'hFF80_0000;
				1:       tau_pick = 32'hFFC0_0000;
				2:       tau_pick = $urandom;
				3:       tau_pick = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
				default: tau_pick = -($urandom_range(1, 1 << 24));
			endcase
			case ($urandom_range(0, 3))
				0:       tol_pick = {$urandom, $urandom};
				1:       tol_pick = 48'h0100_0000_0000;
				2:       tol_pick = 0;
				default: tol_pick = 48'hFFFF_FFFF_FFFF;
			endcase
			set_config(n, tau_pick, tol_pick, $urandom_range(0, 40));
			idle_mode = ph % 3;
			for (int k = 0; k < 3; k++) begin
				if ($urandom_range(0, 3) != 0 || !system_loaded(n))
					load_system(n, 1);
				else
					queue_item(CMD_GUESS, $urandom_range(0, 63), 0, any_value());
				queue_item(CMD_START, 0, 0, 0);
				// back-to-back starts continue from the previous solution
				if ($urandom_range(0, 3) == 0)
					queue_item(CMD_START, 0, 0, 0);
			end
		end

		wait_drained();
		repeat (50) @(negedge clk);
		$display("%0d items sent, %0d solves run, %0d solution items checked",
			items_queued, solves_done, results_checked);
		if (errors == 0 && expected_solutions.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
